>>> hw/rtl/sm4_pkg.sv
// ============================================================================
// SM4 package
// Shared constants, tables, types and helper functions of the SM4 block.
// ============================================================================
package sm4_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int RK_ADDR_W   = $clog2(ROUND_COUNT);
    localparam int WORD_W      = 32;

    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } sm4_state_t;

    localparam logic [7:0] SBOX_TABLE [0:255] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7, 8'h16, 8'hb6, 8'h14, 8'hc2,
        8'h28, 8'hfb, 8'h2c, 8'h05, 8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9c, 8'h42, 8'h50, 8'hf4,
        8'h91, 8'hef, 8'h98, 8'h7a, 8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95, 8'h80, 8'hdf, 8'h94, 8'hfa,
        8'h75, 8'h8f, 8'h3f, 8'ha6, 8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8, 8'h68, 8'h6b, 8'h81, 8'hb2,
        8'h71, 8'h64, 8'hda, 8'h8b, 8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2, 8'h25, 8'h22, 8'h7c, 8'h3b,
        8'h01, 8'h21, 8'h78, 8'h87, 8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e, 8'hea, 8'hbf, 8'h8a, 8'hd2,
        8'h40, 8'hc7, 8'h38, 8'hb5, 8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55, 8'had, 8'h93, 8'h32, 8'h30,
        8'hf5, 8'h8c, 8'hb1, 8'he3, 8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f, 8'hd5, 8'hdb, 8'h37, 8'h45,
        8'hde, 8'hfd, 8'h8e, 8'h2f, 8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f, 8'h11, 8'hd9, 8'h5c, 8'h41,
        8'h1f, 8'h10, 8'h5a, 8'hd8, 8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0, 8'h89, 8'h69, 8'h97, 8'h4a,
        8'h0c, 8'h96, 8'h77, 8'h7e, 8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20, 8'h79, 8'hee, 8'h5f, 8'h3e,
        8'hd7, 8'hcb, 8'h39, 8'h48
    };

    localparam logic [31:0] CK_TABLE [0:ROUND_COUNT-1] = '{
        32'h00070e15, 32'h1c232a31, 32'h383f464d, 32'h545b6269,
        32'h70777e85, 32'h8c939aa1, 32'ha8afb6bd, 32'hc4cbd2d9,
        32'he0e7eef5, 32'hfc030a11, 32'h181f262d, 32'h343b4249,
        32'h50575e65, 32'h6c737a81, 32'h888f969d, 32'ha4abb2b9,
        32'hc0c7ced5, 32'hdce3eaf1, 32'hf8ff060d, 32'h141b2229,
        32'h30373e45, 32'h4c535a61, 32'h686f767d, 32'h848b9299,
        32'ha0a7aeb5, 32'hbcc3cad1, 32'hd8dfe6ed, 32'hf4fb0209,
        32'h10171e25, 32'h2c333a41, 32'h484f565d, 32'h646b7279
    };

    function automatic logic [31:0] subst_word(input logic [31:0] v);
        return {SBOX_TABLE[v[31:24]], SBOX_TABLE[v[23:16]],
                SBOX_TABLE[v[15:8]], SBOX_TABLE[v[7:0]]};
    endfunction

    function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

endpackage

>>> hw/rtl/sm4_ram.sv
// ============================================================================
// SM4 generic RAM
// Single write port, single read port, read data registered.
// ============================================================================
module sm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/sm4_round.sv
// ============================================================================
// SM4 round function
// One round of the cipher or of the key schedule, selected by key_mode.
// ============================================================================
module sm4_round (
    input  logic [127:0] work,
    input  logic [31:0]  rk,
    input  logic         key_mode,
    output logic [31:0]  new_word
);

    logic [31:0] mix_in;
    logic [31:0] subst;
    logic [31:0] lin;

    always_comb
    begin
        mix_in = work[95:64] ^ work[63:32] ^ work[31:0] ^ rk;
        subst  = sm4_pkg::subst_word(mix_in);
        if (key_mode)
        begin
            lin = subst ^ sm4_pkg::rol(subst, 13) ^ sm4_pkg::rol(subst, 23);
        end
        else
        begin
            lin = subst ^ sm4_pkg::rol(subst, 2) ^ sm4_pkg::rol(subst, 10)
                ^ sm4_pkg::rol(subst, 18) ^ sm4_pkg::rol(subst, 24);
        end
        new_word = work[127:96] ^ lin;
    end

endmodule

>>> hw/rtl/sm4_block_encrypt.sv
// ============================================================================
// SM4 block encryption, ECB mode
// The key is written over the APB port as key_high at 0x0 and key_low at 0x8.
// A plaintext block is one transfer on the plain channel; its ciphertext
// leaves as one transfer on the cipher channel.
// Round keys live in a 32-word RAM with registered read data. The first
// block after reset or after any key write first runs the key schedule, one
// round key per cycle. A block then passes through a load state, the round
// state for all 32 rounds and a done state that fills the output register.
// The block returns to idle before it takes the next transfer, so it cannot
// accept a new plaintext before the last one is finished. The single round
// unit is shared by key schedule and cipher.
// The block is ready for a new plaintext while the previous ciphertext still
// waits in the output register. When the receiver stalls, a finished block
// waits in the done state until the output register is free.
// Reset clears the key registers to zero and marks the round keys invalid.
// The user writes keys only while idle; the block does not enforce this.
// ============================================================================
module sm4_block_encrypt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        plain_valid,
    output logic        plain_ready,
    input  logic [63:0] plain_high,
    input  logic [63:0] plain_low,
    output logic        cipher_valid,
    input  logic        cipher_ready,
    output logic [63:0] cipher_high,
    output logic [63:0] cipher_low
);

    localparam int AW = sm4_pkg::RK_ADDR_W;

    sm4_pkg::sm4_state_t state_reg, state_next;

    logic [63:0]   key_high_reg, key_high_next;
    logic [63:0]   key_low_reg, key_low_next;
    logic          keys_ready_reg, keys_ready_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [127:0]  work_reg, work_next;
    logic [127:0]  block_reg, block_next;
    logic          cipher_valid_reg, cipher_valid_next;
    logic [63:0]   cipher_high_reg, cipher_high_next;
    logic [63:0]   cipher_low_reg, cipher_low_next;

    logic          cfg_wr;
    logic          cfg_hit;
    logic          plain_xfer;
    logic          key_mode;
    logic [31:0]   rk;
    logic [31:0]   new_word;
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;
    logic          last_round;

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign cfg_hit    = (paddr[2:0] == 3'd0);
    assign prdata     = !cfg_hit ? 64'd0
                      : (paddr[3] == sm4_pkg::REG_KEY_LOW) ? key_low_reg : key_high_reg;
    assign plain_ready = (state_reg == sm4_pkg::ST_IDLE);
    assign plain_xfer  = plain_valid && plain_ready;
    assign last_round  = (cnt_reg == AW'(sm4_pkg::ROUND_COUNT - 1));

    assign key_mode  = (state_reg == sm4_pkg::ST_EXPAND);
    assign rk        = key_mode ? sm4_pkg::CK_TABLE[cnt_reg] : ram_rdata;
    assign ram_we    = key_mode;
    assign ram_raddr = (state_reg == sm4_pkg::ST_ROUND) ? cnt_reg + AW'(1) : cnt_reg;

    assign cipher_valid = cipher_valid_reg;
    assign cipher_high  = cipher_high_reg;
    assign cipher_low   = cipher_low_reg;

    sm4_round u_round (
        .work     (work_reg),
        .rk       (rk),
        .key_mode (key_mode),
        .new_word (new_word)
    );

    sm4_ram #(
        .WIDTH (sm4_pkg::WORD_W),
        .DEPTH (sm4_pkg::ROUND_COUNT)
    ) u_rk_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg),
        .wdata (new_word),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next        = state_reg;
        key_high_next     = key_high_reg;
        key_low_next      = key_low_reg;
        keys_ready_next   = keys_ready_reg;
        cnt_next          = cnt_reg;
        work_next         = work_reg;
        block_next        = block_reg;
        cipher_valid_next = cipher_valid_reg;
        cipher_high_next  = cipher_high_reg;
        cipher_low_next   = cipher_low_reg;

        if (cipher_valid_reg && cipher_ready)
        begin
            cipher_valid_next = 1'b0;
        end

        case (state_reg)
            sm4_pkg::ST_IDLE:
            begin
                if (plain_xfer)
                begin
                    block_next = {plain_high, plain_low};
                    cnt_next   = '0;
                    if (keys_ready_reg)
                    begin
                        work_next  = {plain_high, plain_low};
                        state_next = sm4_pkg::ST_LOAD;
                    end
                    else
                    begin
                        work_next  = {key_high_reg[63:32] ^ sm4_pkg::FK0,
                                      key_high_reg[31:0]  ^ sm4_pkg::FK1,
                                      key_low_reg[63:32]  ^ sm4_pkg::FK2,
                                      key_low_reg[31:0]   ^ sm4_pkg::FK3};
                        state_next = sm4_pkg::ST_EXPAND;
                    end
                end
            end
            sm4_pkg::ST_EXPAND:
            begin
                work_next = {work_reg[95:0], new_word};
                cnt_next  = cnt_reg + AW'(1);
                if (last_round)
                begin
                    keys_ready_next = 1'b1;
                    work_next       = block_reg;
                    state_next      = sm4_pkg::ST_LOAD;
                end
            end
            sm4_pkg::ST_LOAD:
            begin
                state_next = sm4_pkg::ST_ROUND;
            end
            sm4_pkg::ST_ROUND:
            begin
                work_next = {work_reg[95:0], new_word};
                cnt_next  = cnt_reg + AW'(1);
                if (last_round)
                begin
                    state_next = sm4_pkg::ST_DONE;
                end
            end
            sm4_pkg::ST_DONE:
            begin
                if (!cipher_valid_reg || cipher_ready)
                begin
                    cipher_valid_next = 1'b1;
                    cipher_high_next  = {work_reg[31:0], work_reg[63:32]};
                    cipher_low_next   = {work_reg[95:64], work_reg[127:96]};
                    state_next        = sm4_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sm4_pkg::ST_IDLE;
            end
        endcase

        if (cfg_wr && cfg_hit)
        begin
            keys_ready_next = 1'b0;
            if (paddr[3] == sm4_pkg::REG_KEY_LOW)
            begin
                key_low_next = pwdata;
            end
            else
            begin
                key_high_next = pwdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sm4_pkg::ST_IDLE;
            key_high_reg     <= '0;
            key_low_reg      <= '0;
            keys_ready_reg   <= 1'b0;
            cnt_reg          <= '0;
            cipher_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            key_high_reg     <= key_high_next;
            key_low_reg      <= key_low_next;
            keys_ready_reg   <= keys_ready_next;
            cnt_reg          <= cnt_next;
            cipher_valid_reg <= cipher_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg        <= work_next;
        block_reg       <= block_next;
        cipher_high_reg <= cipher_high_next;
        cipher_low_reg  <= cipher_low_next;
    end

    a_key_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && cfg_hit) |=> !keys_ready_reg)
        else $error("Round keys still marked valid after a key write.");

    a_keys_before_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sm4_pkg::ST_ROUND) |-> keys_ready_reg)
        else $error("Cipher rounds started without a valid key schedule.");

    a_expand_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sm4_pkg::ST_EXPAND && last_round) |=> keys_ready_reg)
        else $error("Key schedule finished without marking round keys valid.");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        plain_xfer |=> (state_reg == sm4_pkg::ST_EXPAND || state_reg == sm4_pkg::ST_LOAD))
        else $error("Accepted block did not start processing.");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sm4_pkg::ST_DONE && cipher_valid_reg && !cipher_ready)
        |=> (state_reg == sm4_pkg::ST_DONE))
        else $error("Finished block left while the output register was full.");

endmodule
